@@ src/dtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg
// Types, codes, constants and field rules shared by the date/time text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

   localparam int unsigned ITEM_QUEUE_DEPTH   = 2;
   localparam int unsigned RESULT_QUEUE_DEPTH = 2;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 14;

   localparam logic [CHAR_W-1:0] CHAR_END     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_P = 8'h70;
   localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

   localparam logic [CHAR_W-1:0] DATE_SEP_RESET = 8'h2D;
   localparam logic [CHAR_W-1:0] TIME_SEP_RESET = 8'h3A;

   localparam int unsigned YEAR_BASE   = 1900;
   localparam int unsigned YEAR_MIN    = 1980;
   localparam int unsigned HOUR_MAX    = 23;
   localparam int unsigned MINSEC_MAX  = 60;
   localparam int unsigned MONTH_MAX   = 12;
   localparam int unsigned DAY_MAX     = 31;
   localparam int unsigned HOUR_ADJUST = 13;
   localparam int unsigned HALF_DAY    = 12;

   localparam logic [1:0] ORDER_MDY = 2'd0;
   localparam logic [1:0] ORDER_DMY = 2'd1;
   localparam logic [1:0] ORDER_YMD = 2'd2;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_TIME_CHAR = 4'd1,
      ST_HOUR      = 4'd2,
      ST_MINUTE    = 4'd3,
      ST_SECOND    = 4'd4,
      ST_DATE_CHAR = 4'd5,
      ST_YEAR      = 4'd6,
      ST_MONTH     = 4'd7,
      ST_DAY       = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      CSR_DATE_SEP   = 2'd0,
      CSR_TIME_SEP   = 2'd1,
      CSR_DATE_ORDER = 2'd2,
      CSR_CLOCK_24H  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ROLE_YEAR  = 2'd0,
      ROLE_MONTH = 2'd1,
      ROLE_DAY   = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      MER_UNDECIDED = 2'd0,
      MER_NONE      = 2'd1,
      MER_AM        = 2'd2,
      MER_PM        = 2'd3
   } meridiem_type;

   typedef struct packed {
      logic [CHAR_W-1:0] date_sep;
      logic [CHAR_W-1:0] time_sep;
      logic [1:0]        date_order;
      logic              clock_24h;
   } cfg_type;

   typedef struct packed {
      logic              op;
      logic [CHAR_W-1:0] code;
      logic              is_end;
      logic              is_digit;
      logic [3:0]        digit;
      logic              is_sep;
      logic              is_a;
      logic              is_p;
   } char_info_type;

   typedef struct packed {
      logic              kind;
      status_type        status;
      logic [CHAR_W-1:0] bad_char;
      logic [4:0]        hours;
      logic [5:0]        minutes;
      logic [5:0]        seconds;
      logic [13:0]       year;
      logic [3:0]        month;
      logic [4:0]        day;
   } rsp_type;

   typedef struct packed {
      status_type         status;
      logic [1:0]         slot;
      logic [VALUE_W-1:0] value;
   } close_type;

   function automatic role_type role_of(input logic [1:0] order, input logic [1:0] pos);
      role_type r;
      unique case (order)
         ORDER_DMY: r = (pos == 2'd0) ? ROLE_DAY : (pos == 2'd1) ? ROLE_MONTH : ROLE_YEAR;
         ORDER_YMD: r = (pos == 2'd0) ? ROLE_YEAR : (pos == 2'd1) ? ROLE_MONTH : ROLE_DAY;
         default:   r = (pos == 2'd0) ? ROLE_MONTH : (pos == 2'd1) ? ROLE_DAY : ROLE_YEAR;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] budget_of(input logic op, input logic [1:0] order,
                                            input logic [1:0] pos);
      return (!op && role_of(order, pos) == ROLE_YEAR) ? 3'd4 : 3'd2;
   endfunction

   // range check and normalization of one finished field
   function automatic close_type close_field(input logic op, input logic [1:0] order,
                                             input logic [1:0] pos,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [6:0] low2);
      close_type          c;
      role_type           r;
      logic [VALUE_W-1:0] y;
      c.status = ST_OK;
      c.slot   = pos;
      c.value  = v;
      r        = role_of(order, pos);
      y        = v;
      if (op) begin
         if (pos == 2'd0) begin
            if (v > VALUE_W'(HOUR_MAX)) c.status = ST_HOUR;
         end else if (v > VALUE_W'(MINSEC_MAX)) begin
            c.status = (pos == 2'd1) ? ST_MINUTE : ST_SECOND;
         end
      end else begin
         c.slot = r;
         unique case (r)
            ROLE_YEAR: begin
               if (v < VALUE_W'(YEAR_BASE)) y = VALUE_W'(YEAR_BASE) + VALUE_W'(low2);
               if (y < VALUE_W'(YEAR_MIN)) c.status = ST_YEAR;
               c.value = y;
            end
            ROLE_MONTH: begin
               if (v == '0) c.value = VALUE_W'(1);
               else if (v > VALUE_W'(MONTH_MAX)) c.status = ST_MONTH;
            end
            default: begin
               if (v == '0) c.value = VALUE_W'(1);
               else if (v > VALUE_W'(DAY_MAX)) c.status = ST_DAY;
            end
         endcase
      end
      return c;
   endfunction

endpackage

@@ src/dtp_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_fifo
// Small register queue with push/full and pop/empty sides, DEPTH of 2 or more.
// ----------------------------------------------------------------------------
module dtp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

@@ src/dtp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_front
// Takes request characters, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module dtp_front
   import dtp_pkg::*;
#(
   parameter int unsigned DEPTH = ITEM_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_operation,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              item_pop,
   output logic              item_empty,
   output char_info_type     item
);

   char_info_type     info;
   logic [CHAR_W-1:0] lower;

   always_comb begin
      lower = (req_char_code >= CHAR_UPPER_A && req_char_code <= CHAR_UPPER_Z)
            ? req_char_code + CASE_OFFSET : req_char_code;
      info.op       = req_operation;
      info.code     = req_char_code;
      info.is_end   = (req_char_code == CHAR_END);
      info.is_digit = (req_char_code >= CHAR_ZERO && req_char_code <= CHAR_NINE);
      info.digit    = req_char_code[3:0];
      // time characters compare case-folded, date characters as they are
      info.is_sep   = (req_char_code != CHAR_END) &&
                      (req_operation ? (lower == cfg.time_sep)
                                     : (req_char_code == cfg.date_sep));
      info.is_a     = (lower == CHAR_LOWER_A);
      info.is_p     = (lower == CHAR_LOWER_P);
   end

   dtp_fifo #(
      .WIDTH ($bits(char_info_type)),
      .DEPTH (DEPTH)
   ) u_item_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (info),
      .full      (req_full),
      .pop       (item_pop),
      .pop_data  (item),
      .empty     (item_empty)
   );

endmodule

@@ src/dtp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_back
// Field FSM: one character per cycle unless the result queue is full.
// ----------------------------------------------------------------------------
module dtp_back
   import dtp_pkg::*;
#(
   parameter int unsigned DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          item_empty,
   input  char_info_type item,
   output logic          item_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output rsp_type       rsp
);

   logic               step;
   logic               rsp_full;
   logic               res_valid;
   rsp_type            res;

   logic [1:0]         field_idx_ff, field_idx_in;
   logic [2:0]         digits_left_ff, digits_left_in;
   logic               loaded_ff, loaded_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [3:0]         tens_ff, tens_in;
   logic [3:0]         units_ff, units_in;
   logic [VALUE_W-1:0] stored_ff [3];
   logic [VALUE_W-1:0] stored_in [3];
   meridiem_type       mer_ff, mer_in;
   logic               err_ff, err_in;
   logic               done_ff, done_in;

   logic [6:0]         low2;
   logic               ap;
   logic               ends0;
   logic [2:0]         dl_eff;
   meridiem_type       mer_char;
   close_type          c0, c1, c2;
   status_type         chain_st;
   logic               finish;
   logic               do_clear;
   logic [4:0]         hour;

   assign step     = !item_empty && !rsp_full;
   assign item_pop = step;

   assign low2     = 7'({3'b000, tens_ff} * 7'd10) + 7'(units_ff);
   assign ap       = item.op && (item.is_a || item.is_p);
   assign ends0    = (loaded_ff && digits_left_ff == '0) || item.is_sep || item.is_end || ap;
   assign dl_eff   = loaded_ff ? digits_left_ff : budget_of(item.op, cfg.date_order, field_idx_ff);
   assign mer_char = item.is_a ? MER_AM : (item.is_p ? MER_PM : MER_NONE);
   assign c0       = close_field(item.op, cfg.date_order, field_idx_ff, acc_ff, low2);
   assign c1       = close_field(item.op, cfg.date_order, 2'd1, '0, '0);
   assign c2       = close_field(item.op, cfg.date_order, 2'd2, '0, '0);

   always_comb begin
      field_idx_in   = field_idx_ff;
      digits_left_in = digits_left_ff;
      loaded_in      = loaded_ff;
      acc_in         = acc_ff;
      tens_in        = tens_ff;
      units_in       = units_ff;
      stored_in      = stored_ff;
      mer_in         = mer_ff;
      err_in         = err_ff;
      done_in        = done_ff;
      res_valid      = 1'b0;
      res            = '0;
      res.kind       = item.op;
      chain_st       = ST_OK;
      finish         = 1'b0;
      do_clear       = 1'b0;
      hour           = '0;
      if (step) begin
         if (err_ff) begin
            if (item.is_end) do_clear = 1'b1;
         end else if (done_ff) begin
            if (item.op && mer_ff == MER_UNDECIDED) mer_in = mer_char;
            finish = item.is_end;
         end else if (ends0) begin
            if (c0.status != ST_OK) begin
               res_valid  = 1'b1;
               res.status = c0.status;
               if (item.is_end) do_clear = 1'b1;
               else err_in = 1'b1;
            end else begin
               stored_in[c0.slot] = c0.value;
               acc_in         = '0;
               tens_in        = '0;
               units_in       = '0;
               loaded_in      = 1'b0;
               digits_left_in = '0;
               if (item.is_sep) begin
                  if (field_idx_ff == 2'd2) done_in = 1'b1;
                  else field_idx_in = field_idx_ff + 2'd1;
               end else if (item.is_end || ap) begin
                  // remaining fields close empty
                  if (field_idx_ff < 2'd1 && c1.status != ST_OK) chain_st = c1.status;
                  else if (field_idx_ff < 2'd2 && c2.status != ST_OK) chain_st = c2.status;
                  if (chain_st != ST_OK) begin
                     res_valid  = 1'b1;
                     res.status = chain_st;
                     if (item.is_end) do_clear = 1'b1;
                     else err_in = 1'b1;
                  end else begin
                     if (field_idx_ff < 2'd1) stored_in[c1.slot] = c1.value;
                     if (field_idx_ff < 2'd2) stored_in[c2.slot] = c2.value;
                     field_idx_in = 2'd2;
                     done_in      = 1'b1;
                     if (item.op && mer_ff == MER_UNDECIDED) mer_in = mer_char;
                     finish = item.is_end;
                  end
               end else if (field_idx_ff == 2'd2) begin
                  done_in = 1'b1;
                  if (item.op && mer_ff == MER_UNDECIDED) mer_in = mer_char;
               end else begin
                  // digit budget spent, character starts the next field
                  field_idx_in = field_idx_ff + 2'd1;
                  if (item.is_digit) begin
                     acc_in         = VALUE_W'(item.digit);
                     units_in       = item.digit;
                     loaded_in      = 1'b1;
                     digits_left_in = budget_of(item.op, cfg.date_order,
                                                field_idx_ff + 2'd1) - 3'd1;
                  end else begin
                     res_valid    = 1'b1;
                     res.status   = item.op ? ST_TIME_CHAR : ST_DATE_CHAR;
                     res.bad_char = item.code;
                     err_in       = 1'b1;
                  end
               end
            end
         end else if (item.is_digit) begin
            acc_in         = VALUE_W'(acc_ff * VALUE_W'(10) + VALUE_W'(item.digit));
            tens_in        = units_ff;
            units_in       = item.digit;
            loaded_in      = 1'b1;
            digits_left_in = dl_eff - 3'd1;
         end else begin
            res_valid    = 1'b1;
            res.status   = item.op ? ST_TIME_CHAR : ST_DATE_CHAR;
            res.bad_char = item.code;
            err_in       = 1'b1;
         end

         if (finish) begin
            res_valid = 1'b1;
            do_clear  = 1'b1;
            if (item.op) begin
               hour = stored_in[0][4:0];
               if (!cfg.clock_24h && stored_in[0] < VALUE_W'(HOUR_ADJUST)) begin
                  if (mer_in == MER_AM && hour == 5'(HALF_DAY)) hour = '0;
                  else if (mer_in == MER_PM && hour != 5'(HALF_DAY)) hour = hour + 5'(HALF_DAY);
               end
               res.hours   = hour;
               res.minutes = stored_in[1][5:0];
               res.seconds = stored_in[2][5:0];
            end else begin
               res.year  = stored_in[ROLE_YEAR];
               res.month = stored_in[ROLE_MONTH][3:0];
               res.day   = stored_in[ROLE_DAY][4:0];
            end
         end

         if (do_clear) begin
            field_idx_in   = '0;
            digits_left_in = '0;
            loaded_in      = 1'b0;
            acc_in         = '0;
            tens_in        = '0;
            units_in       = '0;
            stored_in[0]   = '0;
            stored_in[1]   = '0;
            stored_in[2]   = '0;
            mer_in         = MER_UNDECIDED;
            err_in         = 1'b0;
            done_in        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_idx_ff   <= '0;
         digits_left_ff <= '0;
         loaded_ff      <= 1'b0;
         acc_ff         <= '0;
         tens_ff        <= '0;
         units_ff       <= '0;
         stored_ff[0]   <= '0;
         stored_ff[1]   <= '0;
         stored_ff[2]   <= '0;
         mer_ff         <= MER_UNDECIDED;
         err_ff         <= 1'b0;
         done_ff        <= 1'b0;
      end else begin
         field_idx_ff   <= field_idx_in;
         digits_left_ff <= digits_left_in;
         loaded_ff      <= loaded_in;
         acc_ff         <= acc_in;
         tens_ff        <= tens_in;
         units_ff       <= units_in;
         stored_ff      <= stored_in;
         mer_ff         <= mer_in;
         err_ff         <= err_in;
         done_ff        <= done_in;
      end
   end

   dtp_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step && res_valid),
      .push_data (res),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp),
      .empty     (rsp_empty)
   );

   a_done_last_field: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> field_idx_ff == 2'd2)
      else $error("string done away from last field");

   a_err_not_done: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> !done_ff)
      else $error("error latched on a finished string");

   a_ok_on_end: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && res.status == ST_OK) |-> item.is_end)
      else $error("ok result on a character other than the end code");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && item.is_end) |=> (field_idx_ff == '0 && !err_ff && !done_ff && !loaded_ff))
      else $error("string state not cleared after end code");

   a_budget_range: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |-> digits_left_ff <= 3'd3)
      else $error("digit budget out of range");

endmodule

@@ src/date_time_text_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_time_text_parser
// Parses date and time strings one character per request. Requests are
// classified and enter a queue of ITEM_DEPTH entries; the back end steps
// the field state once per cycle while an item waits and the result queue
// has room, and pushes results into a queue of RESULT_DEPTH entries.
// Sustained rate is one character per cycle while results are popped. The
// end code (or offending character) passes through the item queue, and its
// result is registered in the result queue before the rsp_ ports show it.
// Requests keep flowing while results wait, until both queues fill. The
// configuration port is always ready and is to be written while idle.
// Queue depths must be 2 or more.
// ----------------------------------------------------------------------------
module date_time_text_parser
   import dtp_pkg::*;
#(
   parameter int unsigned ITEM_DEPTH   = ITEM_QUEUE_DEPTH,
   parameter int unsigned RESULT_DEPTH = RESULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_operation,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic              rsp_kind,
   output logic [3:0]        rsp_status,
   output logic [CHAR_W-1:0] rsp_bad_char,
   output logic [4:0]        rsp_hours,
   output logic [5:0]        rsp_minutes,
   output logic [5:0]        rsp_seconds,
   output logic [13:0]       rsp_year,
   output logic [3:0]        rsp_month,
   output logic [4:0]        rsp_day,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [CHAR_W-1:0] csr_data
);

   cfg_type       cfg_ff, cfg_in;
   logic          item_pop;
   logic          item_empty;
   char_info_type item;
   rsp_type       rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DATE_SEP:   cfg_in.date_sep   = csr_data;
            CSR_TIME_SEP:   cfg_in.time_sep   = csr_data;
            CSR_DATE_ORDER: cfg_in.date_order = csr_data[1:0];
            CSR_CLOCK_24H:  cfg_in.clock_24h  = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.date_sep   <= DATE_SEP_RESET;
         cfg_ff.time_sep   <= TIME_SEP_RESET;
         cfg_ff.date_order <= ORDER_MDY;
         cfg_ff.clock_24h  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtp_front #(
      .DEPTH (ITEM_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .item_pop      (item_pop),
      .item_empty    (item_empty),
      .item          (item)
   );

   dtp_back #(
      .DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_empty (item_empty),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   assign rsp_kind     = rsp.kind;
   assign rsp_status   = rsp.status;
   assign rsp_bad_char = rsp.bad_char;
   assign rsp_hours    = rsp.hours;
   assign rsp_minutes  = rsp.minutes;
   assign rsp_seconds  = rsp.seconds;
   assign rsp_year     = rsp.year;
   assign rsp_month    = rsp.month;
   assign rsp_day      = rsp.day;

endmodule

@@ test/date_time_text_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_time_text_parser_tb
// Self-checking bench for the date/time text parser. A queue-fed driver pushes
// character requests and a built-in parser model predicts every result. The
// monitor pops results and compares them field by field with the prediction.
// The run starts with short directed strings. It then sends random
// well-formed, damaged and noise strings under twelve register settings and
// three push/pop idling mixes.
// ----------------------------------------------------------------------------
module date_time_text_parser_tb;
   import dtp_pkg::*;

   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned GROUP_ITEMS   = 117;
   localparam int unsigned GROUPS        = 12;

   localparam logic [CHAR_W-1:0] DATE_SEPS [GROUPS] = '{
      8'h2D, 8'h2F, 8'h00, 8'h2E, 8'hFF, 8'h2D, 8'h20, 8'h2F, 8'h2D, 8'h35, 8'h2D, 8'h2E};
   localparam logic [CHAR_W-1:0] TIME_SEPS [GROUPS] = '{
      8'h3A, 8'h2E, 8'hFF, 8'h3A, 8'h00, 8'h68, 8'h3A, 8'h48, 8'h20, 8'h3A, 8'h3A, 8'h3A};

   typedef struct packed {
      logic              op;
      logic [CHAR_W-1:0] code;
   } text_char_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_push      = 1'b0;
   logic              req_full;
   logic              req_operation = 1'b0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic              rsp_pop       = 1'b0;
   logic              rsp_empty;
   logic              rsp_kind;
   logic [3:0]        rsp_status;
   logic [CHAR_W-1:0] rsp_bad_char;
   logic [4:0]        rsp_hours;
   logic [5:0]        rsp_minutes;
   logic [5:0]        rsp_seconds;
   logic [13:0]       rsp_year;
   logic [3:0]        rsp_month;
   logic [4:0]        rsp_day;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index     = CSR_DATE_SEP;
   logic [CHAR_W-1:0] csr_data      = '0;

   text_char_type     pending_chars[$];
   logic [CHAR_W-1:0] text_buf[$];
   rsp_type           expected_results[$];
   int unsigned       push_idle_pct = 0;
   int unsigned       pop_idle_pct  = 0;
   int unsigned       idle_cycles   = 0;
   int                error_count   = 0;

   // parser model state and register copy
   logic [CHAR_W-1:0]  cfg_date_sep = DATE_SEP_RESET;
   logic [CHAR_W-1:0]  cfg_time_sep = TIME_SEP_RESET;
   logic [1:0]         cfg_order    = ORDER_MDY;
   logic               cfg_24h      = 1'b0;
   logic [1:0]         fld_index;
   logic [2:0]         fld_budget;
   logic               fld_loaded;
   logic [VALUE_W-1:0] fld_value;
   logic [VALUE_W-1:0] fld_store [3];
   meridiem_type       am_pm;
   logic               err_seen;
   logic               fields_done;

   date_time_text_parser u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_char_code (req_char_code),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_bad_char  (rsp_bad_char),
      .rsp_hours     (rsp_hours),
      .rsp_minutes   (rsp_minutes),
      .rsp_seconds   (rsp_seconds),
      .rsp_year      (rsp_year),
      .rsp_month     (rsp_month),
      .rsp_day       (rsp_day),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_parse();
      fld_index   = '0;
      fld_budget  = '0;
      fld_loaded  = 1'b0;
      fld_value   = '0;
      fld_store   = '{default: '0};
      am_pm       = MER_UNDECIDED;
      err_seen    = 1'b0;
      fields_done = 1'b0;
   endfunction

   function automatic role_type role_for(input logic [1:0] pos);
      role_type r;
      case (cfg_order)
         ORDER_DMY: begin
            if (pos == 2'd0) r = ROLE_DAY;
            else if (pos == 2'd1) r = ROLE_MONTH;
            else r = ROLE_YEAR;
         end
         ORDER_YMD: begin
            if (pos == 2'd0) r = ROLE_YEAR;
            else if (pos == 2'd1) r = ROLE_MONTH;
            else r = ROLE_DAY;
         end
         default: begin
            if (pos == 2'd0) r = ROLE_MONTH;
            else if (pos == 2'd1) r = ROLE_DAY;
            else r = ROLE_YEAR;
         end
      endcase
      return r;
   endfunction

   // advances the parser model by one character, queues any result it gives
   function automatic void parse_char(input logic op, input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] low;
      logic              is_sep;
      logic              ends;
      logic              stop;
      status_type        st;
      int unsigned       v;
      int unsigned       h;
      logic [1:0]        pos;
      role_type          r;
      rsp_type           res;
      low      = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? ch + CASE_OFFSET : ch;
      res      = '0;
      res.kind = op;
      if (err_seen) begin
         if (ch == CHAR_END) clear_parse();
         return;
      end
      stop = 1'b0;
      while (!stop) begin
         if (fields_done) begin
            if (op && am_pm == MER_UNDECIDED) begin
               if (low == CHAR_LOWER_A) am_pm = MER_AM;
               else if (low == CHAR_LOWER_P) am_pm = MER_PM;
               else am_pm = MER_NONE;
            end
            stop = 1'b1;
         end else begin
            if (!fld_loaded) begin
               fld_budget = (!op && role_for(fld_index) == ROLE_YEAR) ? 3'd4 : 3'd2;
               fld_loaded = 1'b1;
            end
            is_sep = ch != CHAR_END && (op ? low == cfg_time_sep : ch == cfg_date_sep);
            ends   = fld_budget == 3'd0 || is_sep || ch == CHAR_END ||
                     (op && (low == CHAR_LOWER_A || low == CHAR_LOWER_P));
            if (ends) begin
               v   = fld_value;
               pos = fld_index;
               st  = ST_OK;
               if (op) begin
                  if (pos == 2'd0 && v > HOUR_MAX) st = ST_HOUR;
                  else if (pos == 2'd1 && v > MINSEC_MAX) st = ST_MINUTE;
                  else if (pos == 2'd2 && v > MINSEC_MAX) st = ST_SECOND;
                  else fld_store[pos] = VALUE_W'(v);
               end else begin
                  r = role_for(pos);
                  case (r)
                     ROLE_YEAR: begin
                        if (v < YEAR_BASE) v = v % 100 + YEAR_BASE;
                        if (v < YEAR_MIN) st = ST_YEAR;
                     end
                     ROLE_MONTH: begin
                        if (v == 0) v = 1;
                        else if (v > MONTH_MAX) st = ST_MONTH;
                     end
                     default: begin
                        if (v == 0) v = 1;
                        else if (v > DAY_MAX) st = ST_DAY;
                     end
                  endcase
                  if (st == ST_OK) fld_store[r] = VALUE_W'(v);
               end
               if (st != ST_OK) begin
                  res.status = st;
                  expected_results.push_back(res);
                  if (ch == CHAR_END) clear_parse();
                  else err_seen = 1'b1;
                  return;
               end
               fld_value  = '0;
               fld_loaded = 1'b0;
               if (fld_index >= 2'd2) fields_done = 1'b1;
               else fld_index = fld_index + 2'd1;
               if (is_sep) stop = 1'b1;
            end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
               fld_value  = VALUE_W'(int'(fld_value) * 10 + int'(ch - CHAR_ZERO));
               fld_budget = fld_budget - 3'd1;
               stop       = 1'b1;
            end else begin
               res.status   = op ? ST_TIME_CHAR : ST_DATE_CHAR;
               res.bad_char = ch;
               expected_results.push_back(res);
               err_seen = 1'b1;
               return;
            end
         end
      end
      if (ch == CHAR_END) begin
         if (op) begin
            h = fld_store[0];
            if (!cfg_24h && h < HOUR_ADJUST) begin
               if (am_pm == MER_AM && h == HALF_DAY) h = 0;
               else if (am_pm == MER_PM && h != HALF_DAY) h = h + HALF_DAY;
            end
            res.hours   = 5'(h);
            res.minutes = 6'(fld_store[1]);
            res.seconds = 6'(fld_store[2]);
         end else begin
            res.year  = fld_store[ROLE_YEAR];
            res.month = 4'(fld_store[ROLE_MONTH]);
            res.day   = 5'(fld_store[ROLE_DAY]);
         end
         res.status = ST_OK;
         expected_results.push_back(res);
         clear_parse();
      end
   endfunction

   function automatic void add_number(input int unsigned v, input int unsigned wid);
      int unsigned div;
      div = 1;
      repeat (wid - 1) div *= 10;
      repeat (wid) begin
         text_buf.push_back(CHAR_ZERO + 8'((v / div) % 10));
         div /= 10;
      end
   endfunction

   // moves the built string plus its end code into the request queue
   function automatic void flush_text(input logic op, input int unsigned mix_pct);
      text_char_type c;
      foreach (text_buf[i]) begin
         c.op   = ($urandom_range(99) < mix_pct) ? !op : op;
         c.code = text_buf[i];
         pending_chars.push_back(c);
      end
      c.op   = op;
      c.code = CHAR_END;
      pending_chars.push_back(c);
      text_buf.delete();
   endfunction

   function automatic void queue_text(input logic op, input string s);
      foreach (s[i]) text_buf.push_back(s[i]);
      flush_text(op, 0);
   endfunction

   function automatic logic [CHAR_W-1:0] meridiem_letter();
      logic [CHAR_W-1:0] letter;
      letter = $urandom_range(1) ? CHAR_LOWER_A : CHAR_LOWER_P;
      if ($urandom_range(1)) letter = letter - CASE_OFFSET;
      return letter;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CHAR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DATE_SEP:   cfg_date_sep = data;
         CSR_TIME_SEP:   cfg_time_sep = data;
         CSR_DATE_ORDER: cfg_order    = data[1:0];
         default:        cfg_24h      = data[0];
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      text_char_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) parse_char(req_operation, req_char_code);
         if (!req_push || !req_full) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= push_idle_pct) begin
               nxt = pending_chars.pop_front();
               req_push      <= 1'b1;
               req_operation <= nxt.op;
               req_char_code <= nxt.code;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $error("result with no request waiting for it, status %0d", rsp_status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("status", want.status, rsp_status);
               check_field("bad_char", want.bad_char, rsp_bad_char);
               check_field("hours", want.hours, rsp_hours);
               check_field("minutes", want.minutes, rsp_minutes);
               check_field("seconds", want.seconds, rsp_seconds);
               check_field("year", want.year, rsp_year);
               check_field("month", want.month, rsp_month);
               check_field("day", want.day, rsp_day);
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned       added;
      int unsigned       v;
      int unsigned       wid;
      int unsigned       full_wid;
      int unsigned       nfld;
      int unsigned       sel;
      int unsigned       mix;
      int unsigned       pick;
      logic              op;
      role_type          role;
      logic [CHAR_W-1:0] sep;
      clear_parse();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            // twelve o'clock am, pm suffix, zero month/day with two-digit year
            queue_text(1'b1, "12a");
            queue_text(1'b1, "1:2:3P");
            queue_text(1'b0, "0-0-80");
            // hour error found on the end code, bad characters
            queue_text(1'b1, "24");
            queue_text(1'b0, "1x5");
            queue_text(1'b1, "\377");
            for (int g = 0; g < GROUPS; g++) begin
               // drain every request before touching registers
               while (!(pending_chars.size() == 0 && !req_push &&
                        expected_results.size() == 0)) @(posedge clock);
               repeat (SETTLE_CYCLES) @(posedge clock);
               push_idle_pct = (g < 4) ? 20 : (g < 8) ? 71 : 0;
               pop_idle_pct  = (g < 4) ? 71 : (g < 8) ? 20 : 0;
               write_csr(CSR_DATE_SEP, (g == 8) ? 8'($urandom_range(255)) : DATE_SEPS[g]);
               write_csr(CSR_TIME_SEP, (g == 10) ? 8'($urandom_range(255)) : TIME_SEPS[g]);
               write_csr(CSR_DATE_ORDER, {6'($urandom_range(63)), 2'(g)});
               write_csr(CSR_CLOCK_24H, {7'($urandom_range(127)), 1'((g / 2) % 2)});
               csr_valid <= 1'b0;
               added = 0;
               while (added < GROUP_ITEMS) begin
                  pick = $urandom_range(99);
                  op   = 1'($urandom_range(1));
                  if (pick < 80) begin
                     nfld = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 3;
                     sep  = op ? cfg_time_sep : cfg_date_sep;
                     for (int f = 0; f < nfld; f++) begin
                        full_wid = 2;
                        if (op) begin
                           if ($urandom_range(9) == 0) v = $urandom_range(99);
                           else v = (f == 0) ? $urandom_range(HOUR_MAX)
                                             : $urandom_range(MINSEC_MAX);
                           wid = (v < 10 && $urandom_range(1)) ? 1 : 2;
                        end else begin
                           role = role_for(2'(f));
                           sel  = $urandom_range(99);
                           case (role)
                              ROLE_YEAR: begin
                                 full_wid = 4;
                                 wid      = 4;
                                 if (sel < 50) v = $urandom_range(2099, YEAR_MIN);
                                 else if (sel < 70) begin
                                    v   = $urandom_range(99);
                                    wid = 2;
                                 end else if (sel < 85) v = $urandom_range(YEAR_MIN - 1, YEAR_BASE);
                                 else begin
                                    v   = $urandom_range(9999);
                                    wid = $urandom_range(1, 4);
                                 end
                              end
                              ROLE_MONTH: begin
                                 v   = (sel < 85) ? $urandom_range(MONTH_MAX) : $urandom_range(99, 13);
                                 wid = (v < 10 && $urandom_range(1)) ? 1 : 2;
                              end
                              default: begin
                                 v   = (sel < 85) ? $urandom_range(DAY_MAX) : $urandom_range(99, 32);
                                 wid = (v < 10 && $urandom_range(1)) ? 1 : 2;
                              end
                           endcase
                        end
                        add_number(v, wid);
                        if (f < nfld - 1 && (wid != full_wid || $urandom_range(4) != 0))
                           text_buf.push_back(sep);
                     end
                     if (op && $urandom_range(99) < 55) begin
                        if ($urandom_range(3) == 0) text_buf.push_back(8'h20);
                        text_buf.push_back(meridiem_letter());
                        if ($urandom_range(1)) text_buf.push_back($urandom_range(1) ? 8'h6D : 8'h4D);
                     end
                     // occasional damage to an otherwise good string
                     if (text_buf.size() != 0 && $urandom_range(99) < 12)
                        text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
                     mix = 2;
                  end else begin
                     repeat ($urandom_range(1, 8)) begin
                        case ($urandom_range(3))
                           0:       text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                           1:       text_buf.push_back(8'($urandom_range(255)));
                           2:       text_buf.push_back(op ? cfg_time_sep : cfg_date_sep);
                           default: text_buf.push_back(meridiem_letter());
                        endcase
                     end
                     mix = 25;
                  end
                  added += text_buf.size() + 1;
                  flush_text(op, mix);
               end
            end
            while (!(pending_chars.size() == 0 && !req_push &&
                     expected_results.size() == 0)) @(posedge clock);
            repeat (2 * SETTLE_CYCLES) @(posedge clock);
         end
         begin
            while (idle_cycles < STALL_LIMIT) @(posedge clock);
         end
      join_any
      if (idle_cycles < STALL_LIMIT && error_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
